>>> rtl/core/uxl_pkg.sv
// Shared types and constants for the buffered serial link with XON/XOFF flow control.
package uxl_pkg;

  localparam int RING_DEPTH = 64;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int FILL_W     = $clog2(RING_DEPTH + 1);
  localparam int LEVEL_W    = 7;
  localparam int CMP_W      = (FILL_W > LEVEL_W) ? FILL_W : LEVEL_W;

  localparam logic [LEVEL_W-1:0] LEVEL_RESET = 7'd32;

  localparam logic [7:0] CH_XON   = 8'h11;
  localparam logic [7:0] CH_XOFF  = 8'h13;
  localparam logic [7:0] CH_ABORT = 8'h03;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_LINE  = 2'd2,
    FUNC_TXRDY = 2'd3
  } func_t;

  // low bit clear means a flow byte is pending
  typedef enum logic [1:0] {
    FLOW_XON_PEND  = 2'd0,
    FLOW_RUN       = 2'd1,
    FLOW_XOFF_PEND = 2'd2,
    FLOW_STOP      = 2'd3
  } flow_t;

  // one tx ring entry; cr marks a newline that goes out as CR then LF
  typedef struct packed {
    logic       cr;
    logic [7:0] b;
  } tx_entry_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

>>> rtl/core/uxl_ifs.sv
// Event and result channel interfaces for the serial link.
interface uxl_in_if;
  import uxl_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] data;
  modport source (output valid, output func, output data, input ready);
  modport sink   (input valid, input func, input data, output ready);
endinterface

interface uxl_out_if;
  import uxl_pkg::*;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       rd_valid;
  logic [7:0] rd_byte;
  logic       write_accepted;
  logic       abort_seen;
  logic       rx_dropped;
  modport source (output valid, output tx_valid, output tx_byte, output rd_valid,
                  output rd_byte, output write_accepted, output abort_seen,
                  output rx_dropped, input ready);
  modport sink   (input valid, input tx_valid, input tx_byte, input rd_valid,
                  input rd_byte, input write_accepted, input abort_seen,
                  input rx_dropped, output ready);
endinterface

>>> rtl/core/uart_xon_xoff_buffered_link_top.sv
// Buffered serial link: rx/tx rings, XON/XOFF flow machine, one event per cycle while results are taken.
// Path: an accepted word is held in the input register until the result register is free;
//   it is processed there and its result word is registered in the result register.
// Throughput: one event word per cycle while the result side is ready; the rings use
//   registered head-entry reads that are refetched each cycle, so events never wait on them.
// Reset (rst, synchronous): rings empty, XON pending, tx not paused, transmitter free,
//   xoff_level 32. Ring contents are not cleared.
module uart_xon_xoff_buffered_link_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [uxl_pkg::LEVEL_W-1:0]   cfg_wdata,
  uxl_in_if.sink                        evt,
  uxl_out_if.source                     res
);
  import uxl_pkg::*;

  logic               s0_valid;
  func_t              s0_func;
  logic [7:0]         s0_data;
  logic               s1_free;
  logic               fire;

  logic [LEVEL_W-1:0] xoff_level;

  logic [7:0]         rx_mem [RING_DEPTH];
  logic [7:0]         rx_q;
  logic [PTR_W-1:0]   rx_head, rx_tail, rx_head_next, rx_tail_next, rx_raddr;
  logic [FILL_W-1:0]  rx_fill, rx_fill_next;
  logic               rx_we;

  tx_entry_t          tx_mem [RING_DEPTH];
  tx_entry_t          tx_q;
  tx_entry_t          tx_wentry;
  logic [PTR_W-1:0]   tx_head, tx_tail, tx_head_next, tx_tail_next, tx_raddr;
  logic [FILL_W-1:0]  tx_fill, tx_fill_next;
  logic [FILL_W-1:0]  tx_cnt, tx_cnt_next;
  logic               tx_half, tx_half_next;
  logic               tx_we;

  flow_t              flow, flow_mid, flow_next;
  logic               tx_paused, tx_paused_next;
  logic               line_idle, line_idle_next;
  logic               send_flow;

  logic               o_tx_valid, o_rd_valid, o_wacc, o_abort, o_drop;
  logic [7:0]         o_tx_byte, o_rd_byte;

  logic               r_tx_valid, r_rd_valid, r_wacc, r_abort, r_drop;
  logic [7:0]         r_tx_byte, r_rd_byte;
  logic               r_valid;

  // handshake: input register and result register
  assign s1_free   = !r_valid || res.ready;
  assign fire      = s0_valid && s1_free;
  assign evt.ready = !s0_valid || s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (evt.valid && evt.ready) begin
      s0_valid <= 1'b1;
    end else if (fire) begin
      s0_valid <= 1'b0;
    end
    if (evt.valid && evt.ready) begin
      s0_func <= func_t'(evt.func);
      s0_data <= evt.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      xoff_level <= LEVEL_RESET;
    end else if (cfg_we) begin
      xoff_level <= cfg_wdata;
    end
  end

  // flow machine next state
  always_comb begin
    logic [FILL_W-1:0] fill_after;
    fill_after = rx_fill + FILL_W'(rx_fill < FILL_W'(RING_DEPTH));
    flow_mid   = flow;
    unique case (s0_func)
      FUNC_READ: begin
        if (flow == FLOW_STOP && rx_fill == FILL_W'(1)) flow_mid = FLOW_XON_PEND;
      end
      FUNC_LINE: begin
        if (s0_data != CH_XOFF && s0_data != CH_XON && flow == FLOW_RUN &&
            CMP_W'(fill_after) >= CMP_W'(xoff_level)) begin
          flow_mid = FLOW_XOFF_PEND;
        end
      end
      FUNC_TXRDY: begin
        if (flow == FLOW_STOP && rx_fill == '0) flow_mid = FLOW_XON_PEND;
      end
      default: begin
      end
    endcase
    send_flow = (line_idle || s0_func == FUNC_TXRDY) && !flow_mid[0];
    flow_next = flow_mid;
    if (send_flow) begin
      unique case (flow_mid)
        FLOW_XON_PEND:  flow_next = FLOW_RUN;
        FLOW_XOFF_PEND: flow_next = FLOW_STOP;
        default:        flow_next = flow_mid;
      endcase
    end
  end

  // datapath and result word
  always_comb begin
    logic [FILL_W-1:0] need;
    logic [FILL_W-1:0] tx_free;
    tx_entry_t         front;
    need           = (s0_data == CH_LF) ? FILL_W'(2) : FILL_W'(1);
    tx_free        = FILL_W'(RING_DEPTH) - tx_fill;
    tx_wentry      = '{cr: (s0_data == CH_LF), b: s0_data};
    rx_head_next   = rx_head;
    rx_tail_next   = rx_tail;
    rx_fill_next   = rx_fill;
    tx_head_next   = tx_head;
    tx_tail_next   = tx_tail;
    tx_fill_next   = tx_fill;
    tx_cnt_next    = tx_cnt;
    tx_half_next   = tx_half;
    tx_paused_next = tx_paused;
    line_idle_next = line_idle;
    rx_we          = 1'b0;
    tx_we          = 1'b0;
    o_tx_valid     = 1'b0;
    o_tx_byte      = '0;
    o_rd_valid     = 1'b0;
    o_rd_byte      = '0;
    o_wacc         = 1'b0;
    o_abort        = 1'b0;
    o_drop         = 1'b0;

    unique case (s0_func)
      FUNC_WRITE: begin
        if (tx_free >= need) begin
          tx_we        = 1'b1;
          tx_tail_next = ptr_inc(tx_tail);
          tx_fill_next = tx_fill + need;
          tx_cnt_next  = tx_cnt + 1'b1;
          o_wacc       = 1'b1;
        end
      end
      FUNC_READ: begin
        if (rx_fill != '0) begin
          o_rd_valid   = 1'b1;
          o_rd_byte    = rx_q;
          rx_head_next = ptr_inc(rx_head);
          rx_fill_next = rx_fill - 1'b1;
        end
      end
      FUNC_LINE: begin
        if (s0_data == CH_XOFF) begin
          tx_paused_next = 1'b1;
        end else if (s0_data == CH_XON) begin
          tx_paused_next = 1'b0;
        end else begin
          o_abort = (s0_data == CH_ABORT);
          if (rx_fill >= FILL_W'(RING_DEPTH)) begin
            o_drop = 1'b1;
          end else begin
            rx_we        = 1'b1;
            rx_tail_next = ptr_inc(rx_tail);
            rx_fill_next = rx_fill + 1'b1;
          end
        end
      end
      FUNC_TXRDY: begin
        line_idle_next = 1'b1;
      end
      default: begin
      end
    endcase

    // one send attempt; flow byte wins over data
    front = (tx_cnt == '0) ? tx_wentry : tx_q;
    if (line_idle_next) begin
      if (send_flow) begin
        o_tx_valid     = 1'b1;
        o_tx_byte      = (flow_mid == FLOW_XON_PEND) ? CH_XON : CH_XOFF;
        line_idle_next = 1'b0;
      end else if (!tx_paused_next && tx_fill_next != '0) begin
        o_tx_valid     = 1'b1;
        line_idle_next = 1'b0;
        tx_fill_next   = tx_fill_next - 1'b1;
        if (front.cr && !tx_half) begin
          o_tx_byte    = CH_CR;
          tx_half_next = 1'b1;
        end else begin
          o_tx_byte    = front.b;
          tx_half_next = 1'b0;
          tx_head_next = ptr_inc(tx_head);
          tx_cnt_next  = tx_cnt_next - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_head   <= '0;
      rx_tail   <= '0;
      rx_fill   <= '0;
      tx_head   <= '0;
      tx_tail   <= '0;
      tx_fill   <= '0;
      tx_cnt    <= '0;
      tx_half   <= 1'b0;
      flow      <= FLOW_XON_PEND;
      tx_paused <= 1'b0;
      line_idle <= 1'b1;
    end else if (fire) begin
      rx_head   <= rx_head_next;
      rx_tail   <= rx_tail_next;
      rx_fill   <= rx_fill_next;
      tx_head   <= tx_head_next;
      tx_tail   <= tx_tail_next;
      tx_fill   <= tx_fill_next;
      tx_cnt    <= tx_cnt_next;
      tx_half   <= tx_half_next;
      flow      <= flow_next;
      tx_paused <= tx_paused_next;
      line_idle <= line_idle_next;
    end
  end

  // rings: head entry is refetched every cycle, with write bypass
  assign rx_raddr = fire ? rx_head_next : rx_head;
  assign tx_raddr = fire ? tx_head_next : tx_head;

  always_ff @(posedge clk) begin
    if (fire && rx_we) begin
      rx_mem[rx_tail] <= s0_data;
    end
    if (fire && rx_we && rx_tail == rx_raddr) begin
      rx_q <= s0_data;
    end else begin
      rx_q <= rx_mem[rx_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (fire && tx_we) begin
      tx_mem[tx_tail] <= tx_wentry;
    end
    if (fire && tx_we && tx_tail == tx_raddr) begin
      tx_q <= tx_wentry;
    end else begin
      tx_q <= tx_mem[tx_raddr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (fire) begin
      r_valid <= 1'b1;
    end else if (res.ready) begin
      r_valid <= 1'b0;
    end
    if (fire) begin
      r_tx_valid <= o_tx_valid;
      r_tx_byte  <= o_tx_byte;
      r_rd_valid <= o_rd_valid;
      r_rd_byte  <= o_rd_byte;
      r_wacc     <= o_wacc;
      r_abort    <= o_abort;
      r_drop     <= o_drop;
    end
  end

  assign res.valid          = r_valid;
  assign res.tx_valid       = r_tx_valid;
  assign res.tx_byte        = r_tx_byte;
  assign res.rd_valid       = r_rd_valid;
  assign res.rd_byte        = r_rd_byte;
  assign res.write_accepted = r_wacc;
  assign res.abort_seen     = r_abort;
  assign res.rx_dropped     = r_drop;

  a_rx_fill_bound: assert property (@(posedge clk) disable iff (rst)
    rx_fill <= FILL_W'(RING_DEPTH))
    else $error("rx fill above ring depth");

  a_tx_entries_le_bytes: assert property (@(posedge clk) disable iff (rst)
    tx_cnt <= tx_fill)
    else $error("tx entry count exceeds byte count");

  a_half_needs_entry: assert property (@(posedge clk) disable iff (rst)
    tx_half |-> (tx_cnt != '0))
    else $error("tx half-sent flag with empty entry ring");

  a_rx_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (rx_fill == '0) |-> (rx_head == rx_tail))
    else $error("rx pointers differ on empty ring");

  a_send_busy: assert property (@(posedge clk) disable iff (rst)
    (fire && o_tx_valid) |=> !line_idle)
    else $error("transmitter still idle after a send");

endmodule

>>> tb/uart_xon_xoff_buffered_link_top_tb.sv
// Self-checking testbench for the buffered XON/XOFF serial link: predicts every result word.
`timescale 1ns / 1ps

module uart_xon_xoff_buffered_link_top_tb;
  import uxl_pkg::*;

  localparam int LONG_HOLD = 400;
  localparam int SEG_LEN   = 85;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rd_valid;
    logic [7:0] rd_byte;
    logic       write_accepted;
    logic       abort_seen;
    logic       rx_dropped;
  } link_word_t;

  typedef enum int {MIX_BALANCED, MIX_RX_FILL, MIX_RX_DRAIN, MIX_TX_HEAVY} mix_t;

  // mirror of the link state; one expected word per event
  class link_scoreboard;
    logic [7:0]         rx_mem [RING_DEPTH];
    logic [7:0]         tx_mem [RING_DEPTH];
    logic [PTR_W-1:0]   rx_head, tx_head;
    logic [FILL_W-1:0]  rx_fill, tx_fill;
    flow_t              flow;
    bit                 paused, line_idle;
    logic [LEVEL_W-1:0] level;
    link_word_t         pending[$];
    int events, checked, failures, tx_sent, reads, refused, drops, aborts;

    function new();
      rx_head   = '0;
      tx_head   = '0;
      rx_fill   = '0;
      tx_fill   = '0;
      flow      = FLOW_XON_PEND;
      paused    = 1'b0;
      line_idle = 1'b1;
      level     = LEVEL_RESET;
    endfunction

    function void set_level(logic [LEVEL_W-1:0] v);
      level = v;
    endfunction

    function logic [PTR_W-1:0] wrap_inc(logic [PTR_W-1:0] p);
      return (int'(p) == RING_DEPTH - 1) ? '0 : p + 1'b1;
    endfunction

    function void push_tx(logic [7:0] b);
      tx_mem[(int'(tx_head) + int'(tx_fill)) % RING_DEPTH] = b;
      tx_fill++;
    endfunction

    function void resume_if_drained();
      if (flow == FLOW_STOP && rx_fill == 0) flow = FLOW_XON_PEND;
    endfunction

    function void note_event(func_t f, logic [7:0] d);
      link_word_t w;
      int         need;
      logic [7:0] b;
      bit         send;
      w = '0;
      b = '0;
      send = 1'b0;
      events++;
      case (f)
        FUNC_WRITE: begin
          need = (d == CH_LF) ? 2 : 1;
          if (RING_DEPTH - int'(tx_fill) >= need) begin
            if (d == CH_LF) push_tx(CH_CR);
            push_tx(d);
            w.write_accepted = 1'b1;
          end else begin
            refused++;
          end
        end
        FUNC_READ: begin
          if (rx_fill != 0) begin
            w.rd_valid = 1'b1;
            w.rd_byte  = rx_mem[rx_head];
            rx_head    = wrap_inc(rx_head);
            rx_fill--;
            reads++;
            resume_if_drained();
          end
        end
        FUNC_LINE: begin
          if (d == CH_XOFF) begin
            paused = 1'b1;
          end else if (d == CH_XON) begin
            paused = 1'b0;
          end else begin
            if (d == CH_ABORT) begin
              w.abort_seen = 1'b1;
              aborts++;
            end
            if (int'(rx_fill) >= RING_DEPTH) begin
              w.rx_dropped = 1'b1;
              drops++;
            end else begin
              rx_mem[(int'(rx_head) + int'(rx_fill)) % RING_DEPTH] = d;
              rx_fill++;
            end
            if (flow == FLOW_RUN && int'(rx_fill) >= int'(level)) flow = FLOW_XOFF_PEND;
          end
        end
        default: begin
          line_idle = 1'b1;
          resume_if_drained();
        end
      endcase
      // every event ends with one transmit attempt; flow bytes go first
      if (line_idle) begin
        if (!flow[0]) begin
          b    = (flow == FLOW_XON_PEND) ? CH_XON : CH_XOFF;
          flow = (flow == FLOW_XON_PEND) ? FLOW_RUN : FLOW_STOP;
          send = 1'b1;
        end else if (!paused && tx_fill != 0) begin
          b       = tx_mem[tx_head];
          tx_head = wrap_inc(tx_head);
          tx_fill--;
          send    = 1'b1;
        end
      end
      if (send) begin
        line_idle  = 1'b0;
        w.tx_valid = 1'b1;
        w.tx_byte  = b;
        tx_sent++;
      end
      pending.push_back(w);
    endfunction

    function string fmt(link_word_t w);
      return $sformatf("tx %0b/%02h rd %0b/%02h acc %0b abort %0b drop %0b", w.tx_valid,
                       w.tx_byte, w.rd_valid, w.rd_byte, w.write_accepted, w.abort_seen,
                       w.rx_dropped);
    endfunction

    function void check_result(link_word_t got);
      link_word_t want;
      if (pending.size() == 0) begin
        failures++;
        if (failures <= 10) $display("%0t: unexpected word: %s", $time, fmt(got));
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.tx_valid !== want.tx_valid || got.tx_byte !== want.tx_byte ||
          got.rd_valid !== want.rd_valid || got.rd_byte !== want.rd_byte ||
          got.write_accepted !== want.write_accepted ||
          got.abort_seen !== want.abort_seen || got.rx_dropped !== want.rx_dropped) begin
        failures++;
        if (failures <= 10)
          $display("%0t: word %0d wrong\n  exp %s\n  got %s", $time, checked, fmt(want),
                   fmt(got));
      end
    endfunction

    function bit clean();
      return failures == 0 && pending.size() == 0;
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [LEVEL_W-1:0]   cfg_wdata;
  uxl_in_if             evt_if ();
  uxl_out_if            res_if ();

  link_scoreboard sb = new();
  bit sender_gaps;
  bit sink_stalls;
  int hold_requests = 0;
  int levels_used = 0;

  uart_xon_xoff_buffered_link_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .evt       (evt_if),
    .res       (res_if)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("timeout: %0d words still expected", sb.pending.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: random stalls, one long hold per request, checks every accepted word
  initial begin : sink_side
    int         hold_left;
    int         holds_done;
    link_word_t got;
    hold_left    = 0;
    holds_done   = 0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (res_if.valid && res_if.ready) begin
        got.tx_valid       = res_if.tx_valid;
        got.tx_byte        = res_if.tx_byte;
        got.rd_valid       = res_if.rd_valid;
        got.rd_byte        = res_if.rd_byte;
        got.write_accepted = res_if.write_accepted;
        got.abort_seen     = res_if.abort_seen;
        got.rx_dropped     = res_if.rx_dropped;
        sb.check_result(got);
      end
      if (hold_requests != holds_done) begin
        holds_done++;
        hold_left = LONG_HOLD;
      end else if (hold_left == 0 && sink_stalls && $urandom_range(0, 4) == 0) begin
        hold_left = $urandom_range(1, 11);
      end
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_event(input func_t f, input logic [7:0] d);
    evt_if.func  <= f;
    evt_if.data  <= d;
    evt_if.valid <= 1'b1;
    do @(posedge clk); while (!evt_if.ready);
    sb.note_event(f, d);
    if (sender_gaps && $urandom_range(0, 5) == 0) begin
      evt_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    evt_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_level(input logic [LEVEL_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_level(v);
    cfg_we    <= 1'b0;
    levels_used++;
  endtask

  function automatic func_t pick_func(mix_t m);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (m)
      MIX_RX_FILL:  return r < 60 ? FUNC_LINE  : r < 65 ? FUNC_READ  : r < 85 ? FUNC_TXRDY
                                                                      : FUNC_WRITE;
      MIX_RX_DRAIN: return r < 55 ? FUNC_READ  : r < 70 ? FUNC_LINE  : r < 88 ? FUNC_TXRDY
                                                                      : FUNC_WRITE;
      MIX_TX_HEAVY: return r < 55 ? FUNC_WRITE : r < 67 ? FUNC_TXRDY : r < 85 ? FUNC_LINE
                                                                      : FUNC_READ;
      default:      return func_t'(r % 4);
    endcase
  endfunction

  function automatic logic [7:0] pick_data(func_t f);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (f == FUNC_LINE) begin
      if (r < 7)  return CH_XOFF;
      if (r < 14) return CH_XON;
      if (r < 20) return CH_ABORT;
    end else if (f == FUNC_WRITE) begin
      if (r < 15) return CH_LF;
      if (r < 20) return CH_CR;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin : source_side
    logic [LEVEL_W-1:0] levels [7];
    mix_t               mix;
    func_t              f;
    evt_if.valid = 1'b0;
    evt_if.func  = FUNC_WRITE;
    evt_if.data  = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    rst          = 1'b1;
    sender_gaps  = 1'b0;
    sink_stalls  = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // startup XON leaves on the first event; newline queues CR first
    send_event(FUNC_WRITE, 8'h00);
    send_event(FUNC_WRITE, 8'hFF);
    send_event(FUNC_WRITE, CH_LF);
    send_event(FUNC_TXRDY, 8'h00);
    send_event(FUNC_TXRDY, 8'hFF);
    send_event(FUNC_READ,  8'h00);           // empty rx ring
    send_event(FUNC_LINE,  8'h00);
    send_event(FUNC_LINE,  8'hFF);
    send_event(FUNC_LINE,  CH_ABORT);        // flagged and stored
    send_event(FUNC_LINE,  CH_XOFF);         // pause data
    send_event(FUNC_TXRDY, 8'h00);
    send_event(FUNC_TXRDY, 8'h55);           // paused: nothing goes out
    send_event(FUNC_WRITE, 8'h41);
    send_event(FUNC_LINE,  CH_XON);          // resume, CR of the queued newline leaves
    send_event(FUNC_TXRDY, 8'h00);
    send_event(FUNC_TXRDY, 8'h00);
    send_event(FUNC_READ,  8'h00);
    send_event(FUNC_READ,  8'h00);
    send_event(FUNC_READ,  8'h00);
    send_event(FUNC_READ,  8'h00);
    send_event(FUNC_TXRDY, 8'h00);
    wait_drained();

    levels = '{LEVEL_RESET, 7'd1, 7'd64, 7'd0, 7'd127, 7'($urandom_range(2, 63)),
               7'($urandom_range(1, 64))};
    for (int p = 0; p < 7; p++) begin
      write_level(levels[p]);
      for (int seg = 0; seg < 3; seg++) begin
        mix = mix_t'($urandom_range(0, 3));
        sender_gaps = (p < 6) && ($urandom_range(0, 3) != 0);
        sink_stalls = (p < 6) && ($urandom_range(0, 3) != 0);
        if ((p == 1 || p == 4) && seg == 0) begin
          // long receiver hold while the sender keeps offering words
          mix = MIX_RX_FILL;
          hold_requests <= hold_requests + 1;
        end
        repeat (SEG_LEN) begin
          f = pick_func(mix);
          send_event(f, pick_data(f));
        end
      end
      wait_drained();
    end

    $display("covered %0d events at %0d xoff levels: %0d words checked, %0d tx bytes,",
             sb.events, levels_used, sb.checked, sb.tx_sent);
    $display("  %0d host reads, %0d refused writes, %0d dropped rx bytes, %0d aborts",
             sb.reads, sb.refused, sb.drops, sb.aborts);
    if (sb.pending.size() != 0) $display("%0d words never arrived", sb.pending.size());
    if (sb.failures > 10) $display("%0d failures in total", sb.failures);
    if (sb.clean()) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> uart_xon_xoff_buffered_link_top.f
rtl/core/uxl_pkg.sv
rtl/core/uxl_ifs.sv
rtl/core/uart_xon_xoff_buffered_link_top.sv
tb/uart_xon_xoff_buffered_link_top_tb.sv
